/* design/i2cbm_pkg.sv */
// Shared types and constants of the bit-level I2C master.
package i2cbm_pkg;

	localparam int unsigned HpW = 16;
	localparam int unsigned ToW = 8;
	localparam int unsigned CfgW = 16;
	localparam int unsigned InW = 16;
	localparam int unsigned OutW = 16;

	localparam logic [HpW-1:0] HALF_PERIOD_RESET = 16'd100;
	localparam logic [ToW-1:0] ACK_TIMEOUT_RESET = 8'd250;
	localparam logic [7:0] MSB_MASK = 8'h80;

	typedef enum logic [0:0] {
		REG_HALF_PERIOD = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [14:0] {
		PH_IDLE    = 15'b000000000000001,
		PH_ST_A    = 15'b000000000000010,
		PH_ST_B    = 15'b000000000000100,
		PH_SP_A    = 15'b000000000001000,
		PH_SP_B    = 15'b000000000010000,
		PH_SP_C    = 15'b000000000100000,
		PH_WR_LO   = 15'b000000001000000,
		PH_WR_HI   = 15'b000000010000000,
		PH_WA_LO   = 15'b000000100000000,
		PH_WA_HI   = 15'b000001000000000,
		PH_WA_POLL = 15'b000010000000000,
		PH_RD_LO   = 15'b000100000000000,
		PH_RD_HI   = 15'b001000000000000,
		PH_RK_LO   = 15'b010000000000000,
		PH_RK_HI   = 15'b100000000000000
	} phase_t;

	typedef struct packed {
		logic       sda_sample;
		logic       send_ack;
		logic [7:0] tx_byte;
		logic [1:0] operation;
		logic       cmd_valid;
	} req_t;

	typedef struct packed {
		logic       ack_error;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_level;
		logic       scl_level;
	} res_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} pins_t;

endpackage

/* design/i2cbm_seq.sv */
// Bus phase sequencer: state registers and the per-request update.
module i2cbm_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  i2cbm_pkg::req_t           req,
	input  logic [i2cbm_pkg::HpW-1:0] half_period,
	input  logic [i2cbm_pkg::ToW-1:0] ack_timeout,
	output i2cbm_pkg::res_t           res
);
	import i2cbm_pkg::*;

	phase_t     ph_q, ph_d, nxt_ph;
	logic [3:0] bits_q, bits_d;
	logic [7:0] sh_q, sh_d;
	logic [HpW-1:0] tick_q, tick_d;
	logic [ToW-1:0] wait_q, wait_d;
	logic       scl_q, sda_q, drv_q, ackc_q, err_q;
	logic       ackc_d, err_d, done_d;
	logic [7:0] rx_q, rx_d;
	pins_t      pins_d;
	logic       go;
	logic [HpW-1:0] hp;
	logic [ToW-1:0] to;
	logic [HpW:0]   tick_inc;
	logic [ToW-1:0] wait_inc;
	logic [3:0]     bits_inc;

	function automatic pins_t enter_pins(phase_t p, logic msb, logic ackc, pins_t cur);
		pins_t r;
		r = cur;
		case (p)
			PH_ST_A:  r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
			PH_ST_B:  r = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
			PH_SP_A:  r = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
			PH_SP_B:  r = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
			PH_SP_C:  r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
			PH_WR_LO: r = '{scl: 1'b0, sda: msb, drv: 1'b1};
			PH_WA_LO, PH_RD_LO: r = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
			PH_RK_LO: r = '{scl: 1'b0, sda: ~ackc, drv: 1'b1};
			default:  r.scl = 1'b1;
		endcase
		return r;
	endfunction

	assign hp       = (half_period == '0) ? HpW'(1) : half_period;
	assign to       = (ack_timeout == '0) ? ToW'(1) : ack_timeout;
	assign tick_inc = {1'b0, tick_q} + (HpW+1)'(1);
	assign wait_inc = wait_q + ToW'(1);
	assign bits_inc = bits_q + 4'd1;

	always_comb begin
		ph_d    = ph_q;
		bits_d  = bits_q;
		sh_d    = sh_q;
		tick_d  = tick_q;
		wait_d  = wait_q;
		ackc_d  = ackc_q;
		err_d   = err_q;
		rx_d    = rx_q;
		done_d  = 1'b0;
		pins_d  = '{scl: scl_q, sda: sda_q, drv: drv_q};
		go      = 1'b0;
		nxt_ph  = PH_IDLE;
		case (ph_q)
			PH_IDLE: begin
				if (req.cmd_valid) begin
					go = 1'b1;
					case (op_t'(req.operation))
						OP_START: nxt_ph = PH_ST_A;
						OP_STOP:  nxt_ph = PH_SP_A;
						OP_WRITE: begin
							sh_d   = req.tx_byte;
							bits_d = 4'd0;
							err_d  = 1'b0;
							nxt_ph = PH_WR_LO;
						end
						default: begin
							sh_d   = 8'd0;
							bits_d = 4'd0;
							ackc_d = req.send_ack;
							nxt_ph = PH_RD_LO;
						end
					endcase
				end
			end
			PH_WA_POLL: begin
				if (!req.sda_sample) begin
					pins_d.scl = 1'b0;
					ph_d       = PH_IDLE;
					tick_d     = '0;
					done_d     = 1'b1;
				end else begin
					wait_d = wait_inc;
					if (wait_inc >= to) begin
						err_d  = 1'b1;
						go     = 1'b1;
						nxt_ph = PH_SP_A;
					end
				end
			end
			default: begin
				if (tick_inc < {1'b0, hp}) begin
					tick_d = tick_inc[HpW-1:0];
				end else begin
					case (ph_q)
						PH_ST_A: begin go = 1'b1; nxt_ph = PH_ST_B; end
						PH_ST_B: begin
							pins_d.scl = 1'b0;
							ph_d       = PH_IDLE;
							tick_d     = '0;
							done_d     = 1'b1;
						end
						PH_SP_A: begin go = 1'b1; nxt_ph = PH_SP_B; end
						PH_SP_B: begin go = 1'b1; nxt_ph = PH_SP_C; end
						PH_SP_C: begin
							ph_d   = PH_IDLE;
							tick_d = '0;
							done_d = 1'b1;
						end
						PH_WR_LO: begin go = 1'b1; nxt_ph = PH_WR_HI; end
						PH_WR_HI: begin
							sh_d   = {sh_q[6:0], 1'b0};
							bits_d = bits_inc;
							go     = 1'b1;
							nxt_ph = (bits_inc >= 4'd8) ? PH_WA_LO : PH_WR_LO;
						end
						PH_WA_LO: begin go = 1'b1; nxt_ph = PH_WA_HI; end
						PH_WA_HI: begin
							wait_d = '0;
							go     = 1'b1;
							nxt_ph = PH_WA_POLL;
						end
						PH_RD_LO: begin go = 1'b1; nxt_ph = PH_RD_HI; end
						PH_RD_HI: begin
							sh_d   = {sh_q[6:0], req.sda_sample};
							bits_d = bits_inc;
							go     = 1'b1;
							nxt_ph = (bits_inc >= 4'd8) ? PH_RK_LO : PH_RD_LO;
						end
						PH_RK_LO: begin go = 1'b1; nxt_ph = PH_RK_HI; end
						PH_RK_HI: begin
							pins_d.scl = 1'b0;
							rx_d       = sh_q;
							ph_d       = PH_IDLE;
							tick_d     = '0;
							done_d     = 1'b1;
						end
						default: begin
							ph_d   = PH_IDLE;
							tick_d = '0;
						end
					endcase
				end
			end
		endcase
		if (go) begin
			ph_d   = nxt_ph;
			tick_d = '0;
			pins_d = enter_pins(nxt_ph, |(sh_d & MSB_MASK), ackc_d, pins_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			bits_q <= 4'd0;
			sh_q   <= 8'd0;
			tick_q <= '0;
			wait_q <= '0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			drv_q  <= 1'b1;
			ackc_q <= 1'b0;
			err_q  <= 1'b0;
			rx_q   <= 8'd0;
		end else if (step) begin
			ph_q   <= ph_d;
			bits_q <= bits_d;
			sh_q   <= sh_d;
			tick_q <= tick_d;
			wait_q <= wait_d;
			scl_q  <= pins_d.scl;
			sda_q  <= pins_d.sda;
			drv_q  <= pins_d.drv;
			ackc_q <= ackc_d;
			err_q  <= err_d;
			rx_q   <= rx_d;
		end
	end

	always_comb begin
		res.scl_level = pins_d.scl;
		res.sda_level = pins_d.sda;
		res.sda_drive = pins_d.drv;
		res.busy_res  = (ph_d != PH_IDLE);
		res.done_res  = done_d;
		res.rx_byte   = rx_d;
		res.ack_error = err_d;
	end

endmodule

/* design/i2c_bit_level_master.sv */
// Bit-level I2C master top level: request register, sequencer, result register.
// A request is held in the request register and its result is captured in the result register.
// Throughput: one request per cycle; tready drops only while the result stage stalls.
// The sequencer update between the request and result registers sets that rate.
// Reset (arst_n low, asynchronous): bus lines driven high, idle, both stages empty,
// half period 100 ticks and ack timeout 250 ticks.
module i2c_bit_level_master (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// [0] cmd_valid, [2:1] operation, [10:3] tx_byte, [11] send_ack, [12] sda_sample
	input  logic [i2cbm_pkg::InW-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
	// [12:5] rx_byte, [13] ack_error
	output logic [i2cbm_pkg::OutW-1:0] m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [i2cbm_pkg::CfgW-1:0] cfg_data
);
	import i2cbm_pkg::*;

	logic           req_valid_s1;
	req_t           req_s1;
	logic           out_valid_q;
	logic [OutW-1:0] out_data_q;
	logic           advance;
	logic           step;
	logic [HpW-1:0] half_period_q;
	logic [ToW-1:0] ack_timeout_q;
	res_t           res;

	assign advance  = !out_valid_q || m_tready;
	assign step     = req_valid_s1 && advance;
	assign s_tready = !req_valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HALF_PERIOD: half_period_q <= cfg_data;
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[ToW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			req_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req_t'(s_tdata[$bits(req_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= OutW'(res);
		end
	end

	i2cbm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req         (req_s1),
		.half_period (half_period_q),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

endmodule
